>>> rtl/tlcf_pkg.sv
// Package for the text line cleanup filter.
// Holds character codes, command codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlcf_pkg;

	localparam int CHAR_W = 7;

	localparam logic [CHAR_W-1:0] CH_NUL      = 7'd0;
	localparam logic [CHAR_W-1:0] CH_NEWLINE  = 7'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE    = 7'd32;
	localparam logic [CHAR_W-1:0] CH_PERCENT  = 7'd37;
	localparam logic [CHAR_W-1:0] CH_BACKTICK = 7'd96;
	localparam logic [CHAR_W-1:0] CH_TILDE    = 7'd126;

	localparam logic [1:0] PUSH_NONE = 2'd0;
	localparam logic [1:0] PUSH_HELD = 2'd1;
	localparam logic [1:0] PUSH_IN   = 2'd2;
	localparam logic [1:0] PUSH_CHQ  = 2'd3;

	localparam logic [1:0] EMIT_RD   = 2'd0;
	localparam logic [1:0] EMIT_HELD = 2'd1;
	localparam logic [1:0] EMIT_CHR  = 2'd2;
	localparam logic [1:0] EMIT_NL   = 2'd3;

	typedef struct packed {
		logic       ld_item;
		logic       clear_line;
		logic       set_comment;
		logic       clear_comment;
		logic       set_seen;
		logic       set_held;
		logic       clear_held;
		logic [1:0] push_sel;
		logic       flush_count;
		logic       flush_last;
		logic       idx_inc;
		logic       emit;
		logic [1:0] emit_sel;
	} cmd_t;

	typedef struct packed {
		logic eoi;
		logic is_backtick;
		logic is_newline;
		logic is_percent;
		logic is_space;
		logic is_printable;
		logic comment;
		logic seen;
		logic held_valid;
		logic count_nz;
		logic last_nz;
		logic flush_done;
		logic slot;
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/tlcf_datapath.sv
// Datapath of the text line cleanup filter: line flags, prefix memory,
// flush index and the output register. Uses tlcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlcf_datapath #(
	parameter int PREFIX_DEPTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [6:0]             in_byte,
	input  wire logic                   in_last,
	input  wire tlcf_pkg::cmd_t         cmd,
	output tlcf_pkg::stat_t             stat,
	input  wire logic                   m_tready,
	output logic                        m_tvalid,
	output logic [6:0]                  out_byte,
	output logic                        out_last,
	output logic                        out_ovf
);

	localparam int CW = $clog2(PREFIX_DEPTH + 1);
	localparam int AW = $clog2(PREFIX_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(PREFIX_DEPTH);

	logic [6:0]    mem [PREFIX_DEPTH];
	logic [CW-1:0] count_q;
	logic [CW-1:0] last_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] lim_q;
	logic          seen_q;
	logic          held_v_q;
	logic [6:0]    held_c_q;
	logic          comment_q;
	logic          ovf_q;
	logic [6:0]    ch_q;
	logic [6:0]    rd_q;
	logic          out_valid_q;
	logic [6:0]    out_byte_q;
	logic          out_last_q;
	logic          out_ovf_q;

	logic [6:0]    push_ch;
	logic          push;
	logic          has_room;
	logic [CW-1:0] idx_next;
	logic [6:0]    emit_ch;

	always_comb begin
		case (cmd.push_sel)
			tlcf_pkg::PUSH_HELD: push_ch = held_c_q;
			tlcf_pkg::PUSH_IN:   push_ch = in_byte;
			tlcf_pkg::PUSH_CHQ:  push_ch = ch_q;
			default:             push_ch = in_byte;
		endcase
	end

	assign push     = (cmd.push_sel != tlcf_pkg::PUSH_NONE);
	assign has_room = (count_q < DEPTH_C);
	assign idx_next = idx_q + CW'(1);

	always_comb begin
		case (cmd.emit_sel)
			tlcf_pkg::EMIT_RD:   emit_ch = rd_q;
			tlcf_pkg::EMIT_HELD: emit_ch = held_c_q;
			tlcf_pkg::EMIT_CHR:  emit_ch = ch_q;
			tlcf_pkg::EMIT_NL:   emit_ch = tlcf_pkg::CH_NEWLINE;
			default:             emit_ch = tlcf_pkg::CH_NEWLINE;
		endcase
	end

	always_comb begin
		stat.eoi          = in_last || (in_byte == tlcf_pkg::CH_NUL);
		stat.is_backtick  = (in_byte == tlcf_pkg::CH_BACKTICK);
		stat.is_newline   = (in_byte == tlcf_pkg::CH_NEWLINE);
		stat.is_percent   = (in_byte == tlcf_pkg::CH_PERCENT);
		stat.is_space     = (in_byte <= tlcf_pkg::CH_SPACE);
		stat.is_printable = (in_byte <= tlcf_pkg::CH_TILDE);
		stat.comment      = comment_q;
		stat.seen         = seen_q;
		stat.held_valid   = held_v_q;
		stat.count_nz     = (count_q != '0);
		stat.last_nz      = (last_q != '0);
		stat.flush_done   = (idx_next == lim_q);
		stat.slot         = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk) begin
		if (push && has_room) begin
			mem[count_q[AW-1:0]] <= push_ch;
		end
		rd_q <= mem[idx_q[AW-1:0]];
		if (cmd.ld_item) begin
			ch_q <= in_byte;
		end
		if (cmd.emit) begin
			out_byte_q <= emit_ch;
			out_last_q <= (cmd.emit_sel == tlcf_pkg::EMIT_NL);
			out_ovf_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			last_q      <= '0;
			idx_q       <= '0;
			lim_q       <= '0;
			seen_q      <= 1'b0;
			held_v_q    <= 1'b0;
			held_c_q    <= '0;
			comment_q   <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.set_comment) begin
				comment_q <= 1'b1;
			end else if (cmd.clear_comment) begin
				comment_q <= 1'b0;
			end
			if (cmd.set_seen) begin
				seen_q <= 1'b1;
			end
			if (cmd.set_held) begin
				held_v_q <= 1'b1;
				held_c_q <= in_byte;
			end
			if (cmd.clear_held) begin
				held_v_q <= 1'b0;
			end
			if (push) begin
				if (has_room) begin
					count_q <= count_q + CW'(1);
					if (push_ch > tlcf_pkg::CH_SPACE) begin
						last_q <= count_q + CW'(1);
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.flush_count) begin
				lim_q   <= count_q;
				idx_q   <= '0;
				count_q <= '0;
				last_q  <= '0;
			end
			if (cmd.flush_last) begin
				lim_q <= last_q;
				idx_q <= '0;
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_next;
			end
			if (cmd.clear_line) begin
				count_q  <= '0;
				last_q   <= '0;
				seen_q   <= 1'b0;
				held_v_q <= 1'b0;
				held_c_q <= '0;
				ovf_q    <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;
	assign out_ovf  = out_ovf_q;

endmodule

`default_nettype wire

>>> rtl/tlcf_controller.sv
// Controller of the text line cleanup filter: decodes each accepted item
// and sequences prefix flush and result emission. Uses tlcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlcf_controller (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire tlcf_pkg::stat_t stat,
	output tlcf_pkg::cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_FL   = 3'd2;
	localparam logic [2:0] ST_HELD = 3'd3;
	localparam logic [2:0] ST_CHR  = 3'd4;
	localparam logic [2:0] ST_NL   = 3'd5;
	localparam logic [2:0] ST_PUSH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       eoi_flush_q;
	logic       eoi_flush_d;
	logic [2:0] after_chr;

	assign s_tready  = (state_q == ST_IDLE);
	assign after_chr = stat.held_valid ? ST_HELD : ST_CHR;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		eoi_flush_d = eoi_flush_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (stat.eoi) begin
						cmd.clear_comment = 1'b1;
						if (!stat.comment && !stat.seen && stat.last_nz) begin
							cmd.flush_last = 1'b1;
							eoi_flush_d    = 1'b1;
							state_d        = ST_RD;
						end else begin
							state_d = ST_NL;
						end
					end else if (stat.comment) begin
						cmd.clear_comment = stat.is_newline;
					end else if (stat.is_backtick) begin
						state_d = ST_IDLE;
					end else if (stat.is_newline || stat.is_percent) begin
						cmd.set_comment = stat.is_percent;
						if (stat.seen) begin
							state_d = ST_NL;
						end else begin
							cmd.clear_line = 1'b1;
						end
					end else if (stat.is_space) begin
						cmd.set_held = !stat.held_valid;
					end else if (stat.is_printable) begin
						cmd.ld_item = 1'b1;
						if (!stat.seen) begin
							cmd.set_seen = 1'b1;
							if (stat.count_nz) begin
								cmd.flush_count = 1'b1;
								eoi_flush_d     = 1'b0;
								state_d         = ST_RD;
							end else begin
								state_d = after_chr;
							end
						end else begin
							state_d = after_chr;
						end
					end else if (stat.seen) begin
						cmd.ld_item = 1'b1;
						state_d     = after_chr;
					end else if (stat.held_valid) begin
						cmd.push_sel   = tlcf_pkg::PUSH_HELD;
						cmd.clear_held = 1'b1;
						cmd.ld_item    = 1'b1;
						state_d        = ST_PUSH;
					end else begin
						cmd.push_sel = tlcf_pkg::PUSH_IN;
					end
				end
			end
			ST_PUSH: begin
				cmd.push_sel = tlcf_pkg::PUSH_CHQ;
				state_d      = ST_IDLE;
			end
			ST_RD: begin
				state_d = ST_FL;
			end
			ST_FL: begin
				if (stat.slot) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = tlcf_pkg::EMIT_RD;
					cmd.idx_inc  = 1'b1;
					if (!stat.flush_done) begin
						state_d = ST_RD;
					end else if (eoi_flush_q) begin
						state_d = ST_NL;
					end else begin
						state_d = after_chr;
					end
				end
			end
			ST_HELD: begin
				if (stat.slot) begin
					cmd.emit       = 1'b1;
					cmd.emit_sel   = tlcf_pkg::EMIT_HELD;
					cmd.clear_held = 1'b1;
					state_d        = ST_CHR;
				end
			end
			ST_CHR: begin
				if (stat.slot) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = tlcf_pkg::EMIT_CHR;
					state_d      = ST_IDLE;
				end
			end
			ST_NL: begin
				if (stat.slot) begin
					cmd.emit       = 1'b1;
					cmd.emit_sel   = tlcf_pkg::EMIT_NL;
					cmd.clear_line = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eoi_flush_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			eoi_flush_q <= eoi_flush_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/text_line_cleanup_filter.sv
// Top level of the text line cleanup filter.
// Instantiates tlcf_controller and tlcf_datapath; uses tlcf_pkg.
//
// The slave channel takes one character item per handshake: s_tdata[6:0]
// is the character, s_tlast marks end of input (a zero character does too).
// The master channel gives cleaned characters; m_tlast marks the newline
// that closes an output line and m_tuser flags dropped prefix characters.
// An item that gives no result leaves s_tready high, except a byte 127
// that follows a held whitespace before the first printable: it makes two
// store writes, the second from the ST_PUSH state, with s_tready low.
// An item that gives results holds s_tready low while they are loaded
// into the output register, one per cycle when the receiver keeps m_tready
// high, apart from a prefix store flush. A first printable after stored
// characters flushes them before its own results. The flush passes
// through ST_RD and ST_FL for every stored character, since every entry
// is read from the store memory and registered before it goes out.
// Reset clears all line state and the output valid flag; the store needs
// no clearing pass. When the receiver stalls, the result waits in the
// output register and a further item is still taken if it gives no result.
`timescale 1ns / 1ps
`default_nettype none

module text_line_cleanup_filter #(
	parameter int PREFIX_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // in_byte[6:0], zero[7]
	input  wire logic       s_tlast,  // end_of_input
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,  // out_byte[6:0], zero[7]
	output logic            m_tlast,  // line_end
	output logic [0:0]      m_tuser   // prefix_overflow[0]
);

	tlcf_pkg::cmd_t  cmd;
	tlcf_pkg::stat_t stat;
	logic [6:0]      out_byte;
	logic            out_ovf;

	tlcf_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tlcf_datapath #(
		.PREFIX_DEPTH (PREFIX_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (s_tdata[6:0]),
		.in_last  (s_tlast),
		.cmd      (cmd),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.out_byte (out_byte),
		.out_last (m_tlast),
		.out_ovf  (out_ovf)
	);

	assign m_tdata = {1'b0, out_byte};
	assign m_tuser = out_ovf;

endmodule

`default_nettype wire

>>> rtl/tlcf_checker.sv
// Port-level checks for the text line cleanup filter and their bind.
// Sees only the top level's ports; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module tlcf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast,
	input wire logic [0:0] m_tuser
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("Output item changed while stalled.");

	a_last_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == 8'd10)
		else $error("Line end item is not a newline.");

	a_newline_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[6:0] != 7'd10 && m_tdata[7] == 1'b0)
		else $error("Newline or stray bit inside a line.");

	a_no_dropped_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:0] != 7'd96 && m_tdata[6:0] != 7'd0
			&& m_tdata[6:0] != 7'd37)
		else $error("Backtick, percent or zero reached the output.");

endmodule

bind text_line_cleanup_filter tlcf_checker u_tlcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire

>>> dv/text_line_cleanup_filter_test.sv
// Self-checking testbench for text_line_cleanup_filter: directed lines, then random
// line-shaped traffic with random idling and a long receiver hold-off.
// Depends on tlcf_pkg and the filter RTL; predicts every cleaned character in-bench.
`timescale 1ns / 1ps

module text_line_cleanup_filter_test;

	localparam int PREFIX_DEPTH = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [6:0] CH_DEL = 7'd127;

	typedef struct packed {
		logic [6:0] ch;
		logic       le;
		logic       ovf;
	} clean_char_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [0:0] m_tuser;

	clean_char_t expected_chars[$];
	int unsigned err_count = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned tx_gap_max = 15;
	int unsigned rx_gap_max = 15;
	int unsigned hold_left = 0;

	logic [6:0]  pfx_mem[PREFIX_DEPTH];
	int unsigned pfx_cnt = 0;
	bit          seen_print = 1'b0;
	bit          held_ok = 1'b0;
	logic [6:0]  held_chr = 7'd0;
	bit          in_cmt = 1'b0;
	bit          ovf_line = 1'b0;

	text_line_cleanup_filter #(
		.PREFIX_DEPTH(PREFIX_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void expect_char(logic [6:0] ch, logic le);
		clean_char_t e;
		e.ch = ch;
		e.le = le;
		e.ovf = ovf_line;
		expected_chars.push_back(e);
	endfunction

	function automatic void prefix_push(logic [6:0] ch);
		if (pfx_cnt < PREFIX_DEPTH) begin
			pfx_mem[pfx_cnt] = ch;
			pfx_cnt++;
		end else begin
			ovf_line = 1'b1;
		end
	endfunction

	function automatic void line_reset();
		pfx_cnt = 0;
		seen_print = 1'b0;
		held_ok = 1'b0;
		held_chr = 7'd0;
		ovf_line = 1'b0;
	endfunction

	function automatic void predict_cleanup(logic [6:0] ch, logic last);
		int unsigned keep;
		keep = 0;
		if (last || ch == tlcf_pkg::CH_NUL) begin
			if (!in_cmt && !seen_print) begin
				for (int unsigned i = 0; i < pfx_cnt; i++)
					if (pfx_mem[i] > tlcf_pkg::CH_SPACE)
						keep = i + 1;
				for (int unsigned i = 0; i < keep; i++)
					expect_char(pfx_mem[i], 1'b0);
			end
			expect_char(tlcf_pkg::CH_NEWLINE, 1'b1);
			line_reset();
			in_cmt = 1'b0;
		end else if (in_cmt) begin
			if (ch == tlcf_pkg::CH_NEWLINE)
				in_cmt = 1'b0;
		end else if (ch == tlcf_pkg::CH_BACKTICK) begin
		end else if (ch == tlcf_pkg::CH_NEWLINE || ch == tlcf_pkg::CH_PERCENT) begin
			if (seen_print)
				expect_char(tlcf_pkg::CH_NEWLINE, 1'b1);
			line_reset();
			if (ch == tlcf_pkg::CH_PERCENT)
				in_cmt = 1'b1;
		end else if (ch <= tlcf_pkg::CH_SPACE) begin
			if (!held_ok) begin
				held_ok = 1'b1;
				held_chr = ch;
			end
		end else if (ch <= tlcf_pkg::CH_TILDE) begin
			if (!seen_print) begin
				for (int unsigned i = 0; i < pfx_cnt; i++)
					expect_char(pfx_mem[i], 1'b0);
				pfx_cnt = 0;
				seen_print = 1'b1;
			end
			if (held_ok)
				expect_char(held_chr, 1'b0);
			held_ok = 1'b0;
			expect_char(ch, 1'b0);
		end else begin
			if (seen_print) begin
				if (held_ok)
					expect_char(held_chr, 1'b0);
				expect_char(ch, 1'b0);
			end else begin
				if (held_ok)
					prefix_push(held_chr);
				prefix_push(ch);
			end
			held_ok = 1'b0;
		end
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic send_char(logic [6:0] ch, logic last);
		int unsigned gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, ch};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predict_cleanup(ch, last);
		items_sent++;
	endtask

	task automatic send_text(string text);
		for (int i = 0; i < text.len(); i++)
			send_char(7'(text[i]), 1'b0);
	endtask

	function automatic logic [6:0] rand_space();
		logic [6:0] c;
		c = 7'($urandom_range(1, 32));
		if (c == tlcf_pkg::CH_NEWLINE)
			c = tlcf_pkg::CH_SPACE;
		return c;
	endfunction

	function automatic logic [6:0] rand_printable();
		logic [6:0] c;
		c = 7'($urandom_range(33, 126));
		if (c == tlcf_pkg::CH_PERCENT)
			c = 7'd35;
		return c;
	endfunction

	task automatic send_random_line();
		int unsigned n_pre;
		int unsigned n_body;
		int unsigned pick;
		if ($urandom_range(0, 7) == 0) begin
			n_pre = $urandom_range(1, 8);
			for (int unsigned k = 0; k < n_pre; k++)
				send_char(7'($urandom_range(0, 127)), $urandom_range(0, 15) == 0);
		end else begin
			n_pre = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 4);
			for (int unsigned k = 0; k < n_pre; k++) begin
				pick = $urandom_range(0, 4);
				if (pick < 2)
					send_char(CH_DEL, 1'b0);
				else if (pick < 4)
					send_char(rand_space(), 1'b0);
				else
					send_char(tlcf_pkg::CH_BACKTICK, 1'b0);
			end
			n_body = $urandom_range(0, 10);
			for (int unsigned k = 0; k < n_body; k++) begin
				pick = $urandom_range(0, 19);
				if (pick < 11)
					send_char(rand_printable(), 1'b0);
				else if (pick < 16)
					send_char(rand_space(), 1'b0);
				else if (pick == 16)
					send_char(CH_DEL, 1'b0);
				else if (pick == 17)
					send_char(tlcf_pkg::CH_BACKTICK, 1'b0);
				else if (pick == 18)
					send_char(tlcf_pkg::CH_PERCENT, 1'b0);
				else
					send_char(tlcf_pkg::CH_NEWLINE, 1'b0);
			end
			pick = $urandom_range(0, 19);
			if (pick < 16)
				send_char(tlcf_pkg::CH_NEWLINE, 1'b0);
			else if (pick < 18)
				send_char(7'($urandom_range(0, 127)), 1'b1);
			else
				send_char(tlcf_pkg::CH_NUL, 1'b0);
		end
	endtask

	task automatic send_random_lines(int unsigned n_items);
		int unsigned stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at)
			send_random_line();
	endtask

	task automatic test_whitespace_collapse();
		send_char(tlcf_pkg::CH_SPACE, 1'b0);
		send_char(7'd33, 1'b0);
		send_char(7'd1, 1'b0);
		send_char(tlcf_pkg::CH_SPACE, 1'b0);
		send_char(tlcf_pkg::CH_BACKTICK, 1'b0);
		send_char(tlcf_pkg::CH_TILDE, 1'b0);
		send_char(7'd9, 1'b0);
		send_char(tlcf_pkg::CH_NEWLINE, 1'b0);
	endtask

	task automatic test_comments_and_blank_lines();
		send_text(" \n");
		send_text("%x\n");
		send_text("q %r\n");
	endtask

	task automatic test_prefix_overflow();
		for (int k = 0; k < 9; k++) begin
			send_char(tlcf_pkg::CH_SPACE, 1'b0);
			send_char(CH_DEL, 1'b0);
		end
		send_char(7'd9, 1'b0);
		send_char(7'd65, 1'b0);
		send_char(CH_DEL, 1'b0);
		send_char(7'd90, 1'b1);
	endtask

	task automatic test_end_of_input();
		send_char(CH_DEL, 1'b0);
		send_char(tlcf_pkg::CH_SPACE, 1'b0);
		send_char(CH_DEL, 1'b0);
		send_char(7'd9, 1'b0);
		send_char(tlcf_pkg::CH_NUL, 1'b0);
		send_char(tlcf_pkg::CH_PERCENT, 1'b0);
		send_char(tlcf_pkg::CH_NEWLINE, 1'b1);
		send_char(tlcf_pkg::CH_NUL, 1'b1);
	endtask

	task automatic test_random_no_idle();
		tx_gap_max = 0;
		rx_gap_max = 0;
		send_random_lines(150);
	endtask

	task automatic test_random_idle();
		tx_gap_max = 15;
		rx_gap_max = 15;
		send_random_lines(250);
	endtask

	task automatic test_output_backpressure();
		tx_gap_max = 0;
		rx_gap_max = 3;
		for (int r = 0; r < 2; r++) begin
			hold_left = 300;
			send_random_lines(50);
		end
	endtask

	// Receiver: checks every accepted item and paces m_tready.
	initial begin
		clean_char_t e;
		int unsigned stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected item out_byte=%0d line_end=%0b",
						m_tdata[6:0], m_tlast));
				end else begin
					e = expected_chars.pop_front();
					if (m_tdata[6:0] !== e.ch)
						report_mismatch($sformatf("out_byte %0d, expected %0d",
							m_tdata[6:0], e.ch));
					if (m_tlast !== e.le)
						report_mismatch($sformatf("line_end %0b, expected %0b", m_tlast, e.le));
					if (m_tuser[0] !== e.ovf)
						report_mismatch($sformatf("prefix_overflow %0b, expected %0b",
							m_tuser[0], e.ovf));
				end
				stall_left = $urandom_range(0, rx_gap_max);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if (hold_left > 0)
				hold_left--;
			m_tready <= (stall_left == 0 && hold_left == 0);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_whitespace_collapse();
		test_comments_and_blank_lines();
		test_prefix_overflow();
		test_end_of_input();
		test_random_no_idle();
		test_random_idle();
		test_output_backpressure();
		s_tvalid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
rtl/tlcf_pkg.sv
rtl/tlcf_datapath.sv
rtl/tlcf_controller.sv
rtl/text_line_cleanup_filter.sv
rtl/tlcf_checker.sv
dv/text_line_cleanup_filter_test.sv
